>>> src/pia_pkg.sv
// Shared codes and helpers for the peripheral interface adapter.
package pia_pkg;

  // Item operation codes
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_SET_CA1 = 3'd2;
  localparam logic [2:0] OP_SET_CA2 = 3'd3;
  localparam logic [2:0] OP_SET_CB1 = 3'd4;
  localparam logic [2:0] OP_SET_CB2 = 3'd5;

  // Register select codes
  localparam logic [1:0] RS_DATA_A = 2'd0;
  localparam logic [1:0] RS_CTRL_A = 2'd1;
  localparam logic [1:0] RS_DATA_B = 2'd2;
  localparam logic [1:0] RS_CTRL_B = 2'd3;

  // Control register bit positions
  localparam int CR_IRQ1   = 7;
  localparam int CR_IRQ2   = 6;
  localparam int CR_C2OUT  = 5;
  localparam int CR_C2B4   = 4;
  localparam int CR_C2B3   = 3;
  localparam int CR_DATA   = 2;
  localparam int CR_C1RISE = 1;
  localparam int CR_C1EN   = 0;

  // Writable control bits (flags are read only)
  localparam logic [7:0] CR_WR_MASK = 8'h3F;

  // Transition on a line in the selected direction
  function automatic logic active_edge(input logic old_lvl, input logic new_lvl,
                                       input logic rising);
    active_edge = rising ? (!old_lvl && new_lvl) : (old_lvl && !new_lvl);
  endfunction

  // C2 output, handshake mode
  function automatic logic is_handshake(input logic [7:0] cr);
    is_handshake = cr[CR_C2OUT] && !cr[CR_C2B4] && !cr[CR_C2B3];
  endfunction

  // C2 output, handshake or pulse mode
  function automatic logic is_strobe(input logic [7:0] cr);
    is_strobe = cr[CR_C2OUT] && !cr[CR_C2B4];
  endfunction

  // C2 output, direct mode
  function automatic logic is_direct(input logic [7:0] cr);
    is_direct = cr[CR_C2OUT] && cr[CR_C2B4];
  endfunction

endpackage

>>> src/peripheral_interface_adapter.sv
// Top level: two-port parallel interface adapter with registered result.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------------
//  input   | in_op, in_reg_select, in_write_data,          | in_valid / in_ready
//          | in_line_level, in_port_a_pins, in_port_b_pins |
//  result  | out_read_data, out_port_a_out, out_port_b_out,| out_valid / out_ready
//          | out_ca2_level, out_cb2_level, out_irq_a/b     |
//
// One item per cycle while out_ready is high: the register state and the
// output register both load at the edge that accepts the item.
// The output register frees itself in the cycle it is taken, so in_ready
// stays high while out_ready is high; it drops only while a result waits.
// Synchronous active-low reset clears the state registers and the valid flag to zero; the result payload is not reset.
module peripheral_interface_adapter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [1:0] in_reg_select,
  input  logic [7:0] in_write_data,
  input  logic       in_line_level,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_port_b_pins,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [7:0] out_port_a_out,
  output logic [7:0] out_port_b_out,
  output logic       out_ca2_level,
  output logic       out_cb2_level,
  output logic       out_irq_a,
  output logic       out_irq_b
);

  // Adapter state
  logic [7:0] ctrl_a_r, ctrl_a_nxt;
  logic [7:0] ctrl_b_r, ctrl_b_nxt;
  logic [7:0] dir_a_r, dir_a_nxt;
  logic [7:0] dir_b_r, dir_b_nxt;
  logic [7:0] out_a_r, out_a_nxt;
  logic [7:0] out_b_r, out_b_nxt;
  logic       ca1_r, ca1_nxt;
  logic       ca2_r, ca2_nxt;
  logic       cb1_r, cb1_nxt;
  logic       cb2_r, cb2_nxt;
  logic [7:0] rd_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] rd_r;
  logic [7:0] pa_out_r;
  logic [7:0] pb_out_r;
  logic       ca2_lvl_r;
  logic       cb2_lvl_r;
  logic       irq_a_r;
  logic       irq_b_r;

  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Next state and read data for one item
  always_comb begin
    ctrl_a_nxt = ctrl_a_r;
    ctrl_b_nxt = ctrl_b_r;
    dir_a_nxt  = dir_a_r;
    dir_b_nxt  = dir_b_r;
    out_a_nxt  = out_a_r;
    out_b_nxt  = out_b_r;
    ca1_nxt    = ca1_r;
    ca2_nxt    = ca2_r;
    cb1_nxt    = cb1_r;
    cb2_nxt    = cb2_r;
    rd_nxt     = 8'h00;

    case (in_op)
      pia_pkg::OP_READ: begin
        unique case (in_reg_select)
          pia_pkg::RS_DATA_A: begin
            if (ctrl_a_r[pia_pkg::CR_DATA]) begin
              // data read strobes CA2 and clears both flags
              if (pia_pkg::is_strobe(ctrl_a_r)) ca2_nxt = ctrl_a_r[pia_pkg::CR_C2B3];
              ctrl_a_nxt[pia_pkg::CR_IRQ1] = 1'b0;
              ctrl_a_nxt[pia_pkg::CR_IRQ2] = 1'b0;
              rd_nxt = (out_a_r & dir_a_r) | (in_port_a_pins & ~dir_a_r);
            end else begin
              rd_nxt = dir_a_r;
            end
          end
          pia_pkg::RS_CTRL_A: rd_nxt = ctrl_a_r;
          pia_pkg::RS_DATA_B: begin
            if (ctrl_b_r[pia_pkg::CR_DATA]) begin
              ctrl_b_nxt[pia_pkg::CR_IRQ1] = 1'b0;
              ctrl_b_nxt[pia_pkg::CR_IRQ2] = 1'b0;
              rd_nxt = (out_b_r & dir_b_r) | (in_port_b_pins & ~dir_b_r);
            end else begin
              rd_nxt = dir_b_r;
            end
          end
          default: rd_nxt = ctrl_b_r;
        endcase
      end
      pia_pkg::OP_WRITE: begin
        unique case (in_reg_select)
          pia_pkg::RS_DATA_A: begin
            if (ctrl_a_r[pia_pkg::CR_DATA]) out_a_nxt = in_write_data;
            else dir_a_nxt = in_write_data;
          end
          pia_pkg::RS_CTRL_A: begin
            ctrl_a_nxt = (ctrl_a_r & ~pia_pkg::CR_WR_MASK) |
                         (in_write_data & pia_pkg::CR_WR_MASK);
            if (pia_pkg::is_direct(ctrl_a_nxt)) ca2_nxt = ctrl_a_nxt[pia_pkg::CR_C2B3];
          end
          pia_pkg::RS_DATA_B: begin
            if (ctrl_b_r[pia_pkg::CR_DATA]) begin
              // data write strobes CB2
              if (pia_pkg::is_strobe(ctrl_b_r)) cb2_nxt = ctrl_b_r[pia_pkg::CR_C2B3];
              out_b_nxt = in_write_data;
            end else begin
              dir_b_nxt = in_write_data;
            end
          end
          default: begin
            ctrl_b_nxt = (ctrl_b_r & ~pia_pkg::CR_WR_MASK) |
                         (in_write_data & pia_pkg::CR_WR_MASK);
            if (pia_pkg::is_direct(ctrl_b_nxt)) cb2_nxt = ctrl_b_nxt[pia_pkg::CR_C2B3];
          end
        endcase
      end
      pia_pkg::OP_SET_CA1: begin
        if (pia_pkg::active_edge(ca1_r, in_line_level, ctrl_a_r[pia_pkg::CR_C1RISE])) begin
          if (ctrl_a_r[pia_pkg::CR_C1EN]) ctrl_a_nxt[pia_pkg::CR_IRQ1] = 1'b1;
          if (pia_pkg::is_handshake(ctrl_a_r)) ca2_nxt = 1'b1;
        end
        ca1_nxt = in_line_level;
      end
      pia_pkg::OP_SET_CA2: begin
        // ignored while CA2 is driven by the adapter
        if (!ctrl_a_r[pia_pkg::CR_C2OUT]) begin
          if (pia_pkg::active_edge(ca2_r, in_line_level, ctrl_a_r[pia_pkg::CR_C2B4]) &&
              ctrl_a_r[pia_pkg::CR_C2B3])
            ctrl_a_nxt[pia_pkg::CR_IRQ2] = 1'b1;
          ca2_nxt = in_line_level;
        end
      end
      pia_pkg::OP_SET_CB1: begin
        if (pia_pkg::active_edge(cb1_r, in_line_level, ctrl_b_r[pia_pkg::CR_C1RISE])) begin
          if (ctrl_b_r[pia_pkg::CR_C1EN]) ctrl_b_nxt[pia_pkg::CR_IRQ1] = 1'b1;
          if (pia_pkg::is_handshake(ctrl_b_r)) cb2_nxt = 1'b1;
        end
        cb1_nxt = in_line_level;
      end
      pia_pkg::OP_SET_CB2: begin
        if (!ctrl_b_r[pia_pkg::CR_C2OUT]) begin
          if (pia_pkg::active_edge(cb2_r, in_line_level, ctrl_b_r[pia_pkg::CR_C2B4]) &&
              ctrl_b_r[pia_pkg::CR_C2B3])
            ctrl_b_nxt[pia_pkg::CR_IRQ2] = 1'b1;
          cb2_nxt = in_line_level;
        end
      end
      default: ;
    endcase
  end

  // State update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a_r <= 8'h00;
      ctrl_b_r <= 8'h00;
      dir_a_r  <= 8'h00;
      dir_b_r  <= 8'h00;
      out_a_r  <= 8'h00;
      out_b_r  <= 8'h00;
      ca1_r    <= 1'b0;
      ca2_r    <= 1'b0;
      cb1_r    <= 1'b0;
      cb2_r    <= 1'b0;
    end else if (accept) begin
      ctrl_a_r <= ctrl_a_nxt;
      ctrl_b_r <= ctrl_b_nxt;
      dir_a_r  <= dir_a_nxt;
      dir_b_r  <= dir_b_nxt;
      out_a_r  <= out_a_nxt;
      out_b_r  <= out_b_nxt;
      ca1_r    <= ca1_nxt;
      ca2_r    <= ca2_nxt;
      cb1_r    <= cb1_nxt;
      cb2_r    <= cb2_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Result payload, loaded with the item
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r      <= rd_nxt;
      pa_out_r  <= out_a_nxt & dir_a_nxt;
      pb_out_r  <= out_b_nxt & dir_b_nxt;
      ca2_lvl_r <= ca2_nxt;
      cb2_lvl_r <= cb2_nxt;
      irq_a_r   <= ctrl_a_nxt[pia_pkg::CR_IRQ1] | ctrl_a_nxt[pia_pkg::CR_IRQ2];
      irq_b_r   <= ctrl_b_nxt[pia_pkg::CR_IRQ1] | ctrl_b_nxt[pia_pkg::CR_IRQ2];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_r;
  assign out_port_a_out = pa_out_r;
  assign out_port_b_out = pb_out_r;
  assign out_ca2_level  = ca2_lvl_r;
  assign out_cb2_level  = cb2_lvl_r;
  assign out_irq_a      = irq_a_r;
  assign out_irq_b      = irq_b_r;

endmodule
